/* rtl/dirty_range_coalescer_unit_assert.svh */
// Assertion macros used by the dirty-range coalescer RTL.
`ifndef DIRTY_RANGE_COALESCER_UNIT_ASSERT_SVH
`define DIRTY_RANGE_COALESCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DRC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("drc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DRC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("drc: next-cycle check failed");

`endif

/* rtl/drc_pkg.sv */
// Shared constants, types and codes of the dirty-range coalescer.
`timescale 1ns / 1ps
package drc_pkg;

    localparam int MAX_RANGES    = 8;
    localparam int BYTES_PER_ROW = 16;
    localparam int ROW_SHIFT     = $clog2(BYTES_PER_ROW);

    localparam int ADDR_W   = 32;
    localparam int END_W    = ADDR_W + 1;
    localparam int ROW_W    = 16;
    localparam int COL_W    = 4;
    localparam int CNT_W    = $clog2(MAX_RANGES + 1);
    localparam int IDX_W    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W = 2 * ADDR_W;
    localparam int M_DATA_W = 2 * ROW_W + 2 * COL_W;

    localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = '1;

    // Input item kinds
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SIZE  = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [END_W-1:0]  end_addr;    // exclusive
    } entry_t;

    typedef enum logic [1:0] {
        CMD_HOLD  = 2'd0,
        CMD_SHIFT = 2'd1,
        CMD_MERGE = 2'd2,
        CMD_LOAD  = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] top_row;
        logic [COL_W-1:0] left_col;
        logic [ROW_W-1:0] bottom_row;
        logic [COL_W-1:0] right_col;
    } rect_t;

endpackage

/* rtl/drc_cell.sv */
// One table cell: holds a range, checks it against a query and merges, shifts or loads.
`timescale 1ns / 1ps
module drc_cell (
    input  logic                      aclk,
    input  drc_pkg::cell_cmd_t        cmd,
    input  drc_pkg::entry_t           neighbor,
    input  drc_pkg::entry_t           load_val,
    input  logic [drc_pkg::ADDR_W-1:0] q_lo,
    input  logic [drc_pkg::END_W-1:0]  q_hi,
    input  logic                      occupied,
    output drc_pkg::entry_t           entry,
    output logic                      hit
);

    drc_pkg::entry_t entry_reg;
    drc_pkg::entry_t entry_next;
    logic [drc_pkg::END_W-1:0] q_lo_ext;

    assign q_lo_ext = drc_pkg::END_W'(q_lo);

    // overlap or touch
    assign hit = occupied
              && (q_lo_ext <= entry_reg.end_addr)
              && (q_hi >= drc_pkg::END_W'(entry_reg.start_addr));

    always_comb begin
        entry_next = entry_reg;
        case (cmd)
            drc_pkg::CMD_HOLD: begin
                entry_next = entry_reg;
            end
            drc_pkg::CMD_SHIFT: begin
                entry_next = neighbor;
            end
            drc_pkg::CMD_MERGE: begin
                if (q_lo < entry_reg.start_addr) begin
                    entry_next.start_addr = q_lo;
                end
                if (q_hi > entry_reg.end_addr) begin
                    entry_next.end_addr = q_hi;
                end
            end
            drc_pkg::CMD_LOAD: begin
                entry_next = load_val;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* rtl/drc_rect.sv */
// Clamps a drained range to the window and turns it into a row/column rectangle.
`timescale 1ns / 1ps
module drc_rect (
    input  logic                       aclk,
    input  logic                       clamp_en,
    input  drc_pkg::entry_t            head,
    input  logic [drc_pkg::ADDR_W-1:0] view_start,
    input  logic [drc_pkg::ADDR_W-1:0] lim,
    output drc_pkg::rect_t             rect
);

    logic [drc_pkg::ADDR_W-1:0] lo_clamp;
    logic [drc_pkg::ADDR_W-1:0] hi_clamp;
    logic                       ok_clamp;

    logic [drc_pkg::ADDR_W-1:0] c_lo_reg;
    logic [drc_pkg::ADDR_W-1:0] c_hi_reg;
    logic                       c_ok_reg;

    logic [drc_pkg::ADDR_W-1:0] rel_first;
    logic [drc_pkg::ADDR_W-1:0] rel_last;
    logic [drc_pkg::ROW_W-1:0]  row_a;
    logic [drc_pkg::ROW_W-1:0]  row_b;

    // stage 1: clamp to [view_start, lim)
    always_comb begin
        lo_clamp = (head.start_addr < view_start) ? view_start : head.start_addr;
        if (head.end_addr > drc_pkg::END_W'(lim)) begin
            hi_clamp = lim;
        end else begin
            hi_clamp = head.end_addr[drc_pkg::ADDR_W-1:0];
        end
        ok_clamp = (lo_clamp < hi_clamp);
    end

    always_ff @(posedge aclk) begin
        if (clamp_en) begin
            c_lo_reg <= lo_clamp;
            c_hi_reg <= hi_clamp;
            c_ok_reg <= ok_clamp;
        end
    end

    // stage 2: window-relative byte positions to rows and columns
    assign rel_first = c_lo_reg - view_start;
    assign rel_last  = c_hi_reg - view_start - drc_pkg::ADDR_W'(1);
    assign row_a     = rel_first[drc_pkg::ROW_SHIFT +: drc_pkg::ROW_W];
    assign row_b     = rel_last[drc_pkg::ROW_SHIFT +: drc_pkg::ROW_W];

    always_comb begin
        rect = '0;
        if (c_ok_reg) begin
            rect.valid      = 1'b1;
            rect.top_row    = row_a;
            rect.bottom_row = row_b;
            if (rel_first[drc_pkg::ADDR_W-1:drc_pkg::ROW_SHIFT]
                == rel_last[drc_pkg::ADDR_W-1:drc_pkg::ROW_SHIFT]) begin
                rect.left_col  = drc_pkg::COL_W'(rel_first[drc_pkg::ROW_SHIFT-1:0]);
                rect.right_col = drc_pkg::COL_W'(rel_last[drc_pkg::ROW_SHIFT-1:0]);
            end else begin
                rect.left_col  = '0;
                rect.right_col = drc_pkg::COL_W'(drc_pkg::BYTES_PER_ROW - 1);
            end
        end
    end

endmodule

/* rtl/dirty_range_coalescer_unit.sv */
// Top level of the dirty-range coalescer: cell chain, sequencer and output register.
`timescale 1ns / 1ps
// Tracks changed byte ranges of a 16-byte-per-row grid view and reports them as
// rectangles. A record transaction (s_tuser = 0) is dropped at capture when
// ignored (zero size or all-ones offset); otherwise it is captured, then checked
// against all cells in parallel for overlap, and merges into the first hit or
// appends. When all MAX_RANGES cells are full and nothing overlaps, the table is
// rotated once around the cell ring to build the bounding range. A flush
// transaction (s_tuser = 1) drains the table through cell 0, each stored range by
// a clamp step and then a convert step, and leaves the table empty; an empty table
// gives one whole-grid result (invalid when the view has no rows). Results sit in
// an output register, so a stalled m_tready only holds the drain. m_tuser carries
// rect_valid, m_tlast marks the final result of a flush. New input is taken only
// between transactions. Configuration writes are accepted whenever the block is
// out of reset and belong between transactions. Neither s_tready nor cfg_ready is
// raised while aresetn is low.
module dirty_range_coalescer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [drc_pkg::S_DATA_W-1:0]   s_tdata,   // change_offset[31:0], change_size[63:32]
    input  logic                           s_tuser,   // op

    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [drc_pkg::M_DATA_W-1:0]   m_tdata,   // top_row[15:0], left_col[19:16],
                                                      // bottom_row[35:20], right_col[39:36]
    output logic                           m_tuser,   // rect_valid
    output logic                           m_tlast,   // last_of_flush

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [drc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int N = drc_pkg::MAX_RANGES;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_MATCH    = 6'b000010,
        ST_COLLAPSE = 6'b000100,
        ST_EMPTY    = 6'b001000,
        ST_CLAMP    = 6'b010000,
        ST_EMIT     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [drc_pkg::ADDR_W-1:0] view_start_reg;
    logic [drc_pkg::ROW_W-1:0]  view_rows_reg;
    logic [drc_pkg::ADDR_W-1:0] data_size_reg;
    logic [drc_pkg::ADDR_W-1:0] lim_reg, lim_next;
    logic [drc_pkg::END_W-1:0]  win_end;

    // sequencer state
    logic [drc_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [drc_pkg::IDX_W-1:0]  step_reg, step_next;   // collapse / drain position
    logic [drc_pkg::ADDR_W-1:0] lo_reg, lo_next;
    logic [drc_pkg::END_W-1:0]  hi_reg, hi_next;
    logic [drc_pkg::ADDR_W-1:0] acc_lo_reg, acc_lo_next;
    logic [drc_pkg::END_W-1:0]  acc_hi_reg, acc_hi_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    drc_pkg::rect_t        out_rect_reg, out_rect_next;
    logic                  out_last_reg, out_last_next;
    logic                  slot_free;
    logic                  out_load;

    // cells
    drc_pkg::cell_cmd_t    cmd [N];
    drc_pkg::entry_t       load_val [N];
    drc_pkg::entry_t       entry [N];
    logic [N-1:0]          hits;
    logic [N-1:0]          first_hit;
    logic [N-1:0]          occupied;
    logic [N-1:0]          merge_mask;
    logic                  any_hit;
    logic                  table_full;

    logic                  s_accept;
    logic [drc_pkg::ADDR_W-1:0] in_offset;
    logic [drc_pkg::ADDR_W-1:0] in_size;
    logic                  collapse_final;
    logic                  drain_last;
    logic [drc_pkg::ADDR_W-1:0] bound_lo;
    logic [drc_pkg::END_W-1:0]  bound_hi;
    drc_pkg::rect_t        drain_rect;
    drc_pkg::rect_t        grid_rect;

    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_offset = s_tdata[drc_pkg::ADDR_W-1:0];
    assign in_size   = s_tdata[drc_pkg::S_DATA_W-1:drc_pkg::ADDR_W];
    assign cfg_ready = aresetn;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_start_reg <= '0;
            view_rows_reg  <= '0;
            data_size_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                drc_pkg::CFG_VIEW_START: view_start_reg <= cfg_data;
                drc_pkg::CFG_VIEW_ROWS:  view_rows_reg  <= cfg_data[drc_pkg::ROW_W-1:0];
                drc_pkg::CFG_DATA_SIZE:  data_size_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Window end clamped to the data size and registered; it is settled before a flush
    // reaches its first clamp step when configuration writes stay between transactions.
    assign win_end = drc_pkg::END_W'(view_start_reg)
                   + (drc_pkg::END_W'(view_rows_reg) << drc_pkg::ROW_SHIFT);
    assign lim_next = (win_end < drc_pkg::END_W'(data_size_reg))
                    ? win_end[drc_pkg::ADDR_W-1:0] : data_size_reg;

    always_ff @(posedge aclk) begin
        lim_reg <= lim_next;
    end

    // ---------------- cell chain ----------------
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            assign occupied[g] = (drc_pkg::CNT_W'(g) < count_reg);
            drc_cell u_cell (
                .aclk     (aclk),
                .cmd      (cmd[g]),
                .neighbor (entry[(g + 1) % N]),   // ring: shifts rotate toward cell 0
                .load_val (load_val[g]),
                .q_lo     (lo_reg),
                .q_hi     (hi_reg),
                .occupied (occupied[g]),
                .entry    (entry[g]),
                .hit      (hits[g])
            );
            assign merge_mask[g] = (cmd[g] == drc_pkg::CMD_MERGE);
        end
    endgenerate

    assign any_hit    = |hits;
    assign first_hit  = hits & ~(hits - N'(1));
    assign table_full = (count_reg == drc_pkg::CNT_W'(N));

    assign collapse_final = (step_reg == drc_pkg::IDX_W'(N - 1));
    assign drain_last     = ((drc_pkg::CNT_W'(step_reg) + drc_pkg::CNT_W'(1)) == count_reg);

    // running bounding range while the table rotates past cell 0
    assign bound_lo = (entry[0].start_addr < acc_lo_reg) ? entry[0].start_addr : acc_lo_reg;
    assign bound_hi = (entry[0].end_addr > acc_hi_reg) ? entry[0].end_addr : acc_hi_reg;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            cmd[i]                 = drc_pkg::CMD_HOLD;
            load_val[i].start_addr = lo_reg;
            load_val[i].end_addr   = hi_reg;
            case (state_reg)
                ST_MATCH: begin
                    if (any_hit) begin
                        cmd[i] = first_hit[i] ? drc_pkg::CMD_MERGE : drc_pkg::CMD_HOLD;
                    end else if (!table_full && (drc_pkg::CNT_W'(i) == count_reg)) begin
                        cmd[i] = drc_pkg::CMD_LOAD;
                    end
                end
                ST_COLLAPSE: begin
                    cmd[i] = drc_pkg::CMD_SHIFT;
                    if (collapse_final && (i == 0)) begin
                        cmd[i]                 = drc_pkg::CMD_LOAD;
                        load_val[i].start_addr = bound_lo;
                        load_val[i].end_addr   = bound_hi;
                    end
                end
                ST_CLAMP: begin
                    cmd[i] = drc_pkg::CMD_SHIFT;
                end
                default: begin
                    cmd[i] = drc_pkg::CMD_HOLD;
                end
            endcase
        end
    end

    // ---------------- rectangle conversion ----------------
    drc_rect u_rect (
        .aclk       (aclk),
        .clamp_en   (state_reg == ST_CLAMP),
        .head       (entry[0]),
        .view_start (view_start_reg),
        .lim        (lim_reg),
        .rect       (drain_rect)
    );

    always_comb begin
        grid_rect = '0;
        if (view_rows_reg != '0) begin
            grid_rect.valid      = 1'b1;
            grid_rect.bottom_row = view_rows_reg - drc_pkg::ROW_W'(1);
            grid_rect.right_col  = drc_pkg::COL_W'(drc_pkg::BYTES_PER_ROW - 1);
        end
    end

    // ---------------- sequencer ----------------
    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        acc_lo_next   = acc_lo_reg;
        acc_hi_next   = acc_hi_reg;
        out_load      = 1'b0;
        out_rect_next = out_rect_reg;
        out_last_next = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == drc_pkg::OP_FLUSH) begin
                        step_next  = '0;
                        state_next = (count_reg == '0) ? ST_EMPTY : ST_CLAMP;
                    end else begin
                        lo_next = in_offset;
                        hi_next = drc_pkg::END_W'(in_offset) + drc_pkg::END_W'(in_size);
                        if ((in_size != '0) && (in_offset != drc_pkg::ADDR_ALL_ONES)) begin
                            state_next = ST_MATCH;
                        end
                    end
                end
            end
            ST_MATCH: begin
                if (any_hit) begin
                    state_next = ST_IDLE;
                end else if (!table_full) begin
                    count_next = count_reg + drc_pkg::CNT_W'(1);
                    state_next = ST_IDLE;
                end else begin
                    acc_lo_next = lo_reg;
                    acc_hi_next = hi_reg;
                    step_next   = '0;
                    state_next  = ST_COLLAPSE;
                end
            end
            ST_COLLAPSE: begin
                acc_lo_next = bound_lo;
                acc_hi_next = bound_hi;
                if (collapse_final) begin
                    count_next = drc_pkg::CNT_W'(1);
                    state_next = ST_IDLE;
                end else begin
                    step_next = step_reg + drc_pkg::IDX_W'(1);
                end
            end
            ST_EMPTY: begin
                if (slot_free) begin
                    out_load      = 1'b1;
                    out_rect_next = grid_rect;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CLAMP: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_load      = 1'b1;
                    out_rect_next = drain_rect;
                    out_last_next = drain_last;
                    if (drain_last) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        step_next  = step_reg + drc_pkg::IDX_W'(1);
                        state_next = ST_CLAMP;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        acc_lo_reg   <= acc_lo_next;
        acc_hi_reg   <= acc_hi_next;
        out_rect_reg <= out_rect_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rect_reg.right_col, out_rect_reg.bottom_row,
                       out_rect_reg.left_col, out_rect_reg.top_row};
    assign m_tuser  = out_rect_reg.valid;
    assign m_tlast  = out_last_reg;

    // ---------------- assertions ----------------
`include "dirty_range_coalescer_unit_assert.svh"

    `DRC_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= drc_pkg::CNT_W'(N))
    `DRC_ASSERT_IMP(a_single_merge, aclk, aresetn, state_reg == ST_MATCH, $onehot0(merge_mask))
    `DRC_ASSERT_NXT(a_flush_empties, aclk, aresetn, (state_reg == ST_EMIT) && slot_free && drain_last, count_reg == '0)
    `DRC_ASSERT_NXT(a_collapse_one, aclk, aresetn, (state_reg == ST_COLLAPSE) && collapse_final, count_reg == drc_pkg::CNT_W'(1))

endmodule

/* sim/dirty_range_coalescer_unit_tb.sv */
// Self-checking testbench for the dirty-range coalescer: record/flush streams against a predictor.
`timescale 1ns / 1ps
module dirty_range_coalescer_unit_tb;

    localparam int QUIET_LIMIT  = 2000;                         // cycles with no transaction at all
    localparam int DRAIN_CYCLES = 2 * drc_pkg::MAX_RANGES + 8;  // covers a collapse or a full drain
    localparam int LONG_HOLD    = 60;

    typedef struct packed {
        logic        op;
        logic [31:0] chg_off;
        logic [31:0] chg_len;
    } edit_t;

    typedef struct packed {
        drc_pkg::rect_t rect;
        logic           last;
    } flush_rect_t;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [drc_pkg::S_DATA_W-1:0]   s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [drc_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [drc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [drc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    dirty_range_coalescer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: view registers and the range table
    logic [31:0] cfg_view_start = '0;
    logic [15:0] cfg_view_rows  = '0;
    logic [31:0] cfg_data_size  = '0;
    logic [31:0] span_lo [drc_pkg::MAX_RANGES];
    logic [32:0] span_hi [drc_pkg::MAX_RANGES];
    int          span_count = 0;

    edit_t       edit_q [$];
    flush_rect_t rect_expect_q [$];
    edit_t       offered;
    flush_rect_t want;

    bit          idle_en = 1'b1;
    int          send_gap = 0;
    int          hold_cnt = 0;
    int          long_holds = 0;
    int          quiet_cycles = 0;
    int          mismatches = 0;
    int          records_sent = 0;
    int          flushes_sent = 0;
    int          results_seen = 0;
    int          invalid_seen = 0;
    int          views_set = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    function automatic void record_change(logic [31:0] chg_off, logic [31:0] chg_len);
        logic [32:0] lo;
        logic [32:0] hi;
        int i;
        lo = {1'b0, chg_off};
        hi = {1'b0, chg_off} + {1'b0, chg_len};
        if (chg_len == 0 || chg_off == drc_pkg::ADDR_ALL_ONES)
            return;
        // first stored range that overlaps or touches absorbs the change
        for (i = 0; i < span_count; i++) begin
            if (lo <= span_hi[i] && hi >= {1'b0, span_lo[i]}) begin
                if (lo < {1'b0, span_lo[i]})
                    span_lo[i] = lo[31:0];
                if (hi > span_hi[i])
                    span_hi[i] = hi;
                return;
            end
        end
        // table full: everything collapses into one bounding range
        if (span_count >= drc_pkg::MAX_RANGES) begin
            for (i = 0; i < drc_pkg::MAX_RANGES; i++) begin
                if ({1'b0, span_lo[i]} < lo)
                    lo = {1'b0, span_lo[i]};
                if (span_hi[i] > hi)
                    hi = span_hi[i];
            end
            span_lo[0] = lo[31:0];
            span_hi[0] = hi;
            span_count = 1;
            return;
        end
        span_lo[span_count] = lo[31:0];
        span_hi[span_count] = hi;
        span_count++;
    endfunction

    function automatic drc_pkg::rect_t clip_to_view(logic [63:0] lo, logic [63:0] hi);
        logic [63:0] win_end;
        logic [63:0] lim;
        logic [63:0] rel_first;
        logic [63:0] rel_last;
        logic [63:0] row_a;
        logic [63:0] row_b;
        drc_pkg::rect_t r;
        r = '0;
        if (lo >= hi || cfg_view_rows == 0 || cfg_view_start == drc_pkg::ADDR_ALL_ONES)
            return r;
        win_end = 64'(cfg_view_start) + 64'(cfg_view_rows) * 64'(drc_pkg::BYTES_PER_ROW);
        lim = (win_end < 64'(cfg_data_size)) ? win_end : 64'(cfg_data_size);
        if (lo < 64'(cfg_view_start))
            lo = 64'(cfg_view_start);
        if (hi > lim)
            hi = lim;
        if (lo >= hi)
            return r;
        rel_first = lo - 64'(cfg_view_start);
        rel_last  = (hi - 1) - 64'(cfg_view_start);
        row_a = rel_first / drc_pkg::BYTES_PER_ROW;
        row_b = rel_last / drc_pkg::BYTES_PER_ROW;
        r.valid      = 1'b1;
        r.top_row    = row_a[drc_pkg::ROW_W-1:0];
        r.bottom_row = row_b[drc_pkg::ROW_W-1:0];
        if (row_a == row_b) begin
            r.left_col  = drc_pkg::COL_W'(rel_first % drc_pkg::BYTES_PER_ROW);
            r.right_col = drc_pkg::COL_W'(rel_last % drc_pkg::BYTES_PER_ROW);
        end else begin
            r.left_col  = '0;
            r.right_col = drc_pkg::COL_W'(drc_pkg::BYTES_PER_ROW - 1);
        end
        return r;
    endfunction

    function automatic void predict_flush();
        flush_rect_t res;
        int i;
        res = '0;
        if (span_count == 0) begin
            // empty table repaints the whole grid, or nothing when there are no rows
            if (cfg_view_rows != 0) begin
                res.rect.valid      = 1'b1;
                res.rect.bottom_row = cfg_view_rows - 1'b1;
                res.rect.right_col  = drc_pkg::COL_W'(drc_pkg::BYTES_PER_ROW - 1);
            end
            res.last = 1'b1;
            rect_expect_q.push_back(res);
        end else begin
            for (i = 0; i < span_count; i++) begin
                res.rect = clip_to_view({32'd0, span_lo[i]}, {31'd0, span_hi[i]});
                res.last = (i == span_count - 1);
                rect_expect_q.push_back(res);
            end
            span_count = 0;
        end
    endfunction

    // ---------------- driver: input stream ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (offered.op == drc_pkg::OP_FLUSH) begin
                    predict_flush();
                    flushes_sent++;
                end else begin
                    record_change(offered.chg_off, offered.chg_len);
                    records_sent++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (edit_q.size() != 0) begin
                    offered = edit_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered.chg_len, offered.chg_off};
                    s_tuser  <= offered.op;
                    if (idle_en && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 3);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor: result stream ----------------

    function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] got);
        if (exp_val !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (!m_tuser)
                    invalid_seen++;
                if (rect_expect_q.size() == 0) begin
                    $error("result with nothing expected: tdata 0x%0h valid %0b last %0b",
                           m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    want = rect_expect_q.pop_front();
                    check_field("rect_valid", want.rect.valid, m_tuser);
                    check_field("top_row", want.rect.top_row, m_tdata[15:0]);
                    check_field("left_col", want.rect.left_col, m_tdata[19:16]);
                    check_field("bottom_row", want.rect.bottom_row, m_tdata[35:20]);
                    check_field("right_col", want.rect.right_col, m_tdata[39:36]);
                    check_field("last_of_flush", want.last, m_tlast);
                end
            end
            // long hold-offs while the sender still has plenty queued: fills the block
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (idle_en && long_holds < 2 && edit_q.size() > 20 &&
                         results_seen >= 20 + 100 * long_holds) begin
                hold_cnt = LONG_HOLD - 1;
                long_holds++;
                m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                hold_cnt = $urandom_range(1, 3) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** dirty_range_coalescer_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------

    // Keeps cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(logic [drc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready))
            @(posedge aclk);
        case (idx)
            drc_pkg::CFG_VIEW_START: cfg_view_start = value;
            drc_pkg::CFG_VIEW_ROWS:  cfg_view_rows  = value[15:0];
            drc_pkg::CFG_DATA_SIZE:  cfg_data_size  = value;
            default: ;
        endcase
    endtask

    task automatic program_view(logic [31:0] start_addr, logic [15:0] rows,
                                logic [31:0] data_len);
        write_reg(drc_pkg::CFG_VIEW_START, start_addr);
        write_reg(drc_pkg::CFG_VIEW_ROWS, {16'd0, rows});
        write_reg(drc_pkg::CFG_DATA_SIZE, data_len);
        cfg_valid <= 1'b0;
        views_set++;
    endtask

    // Sender pause: nothing new goes in until every expected rect is back.
    task automatic wait_idle();
        while (edit_q.size() != 0 || s_tvalid || rect_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic add_edit(logic op, logic [31:0] chg_off, logic [31:0] chg_len);
        edit_t e;
        e.op      = op;
        e.chg_off = chg_off;
        e.chg_len = chg_len;
        edit_q.push_back(e);
    endtask

    // Mostly changes near the visible window, some far away, some ignored.
    function automatic edit_t random_record(int unsigned span);
        edit_t e;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        e.op = drc_pkg::OP_RECORD;
        if (pick == 0) begin
            e.chg_off = $urandom;
            e.chg_len = $urandom;
        end else if (pick == 1) begin
            e.chg_off = $urandom;
            e.chg_len = '0;
        end else if (pick == 2) begin
            e.chg_off = drc_pkg::ADDR_ALL_ONES;
            e.chg_len = $urandom;
        end else begin
            e.chg_off = cfg_view_start - 32'd32 + $urandom_range(0, span + 64);
            e.chg_len = (pick < 15) ? $urandom_range(1, 20) : $urandom_range(1, span + 32);
        end
        return e;
    endfunction

    task automatic run_random_phase(logic [31:0] start_addr, logic [15:0] rows,
                                    logic [31:0] data_len, int unsigned count);
        int unsigned queued;
        int unsigned k;
        int unsigned i;
        int unsigned span;
        program_view(start_addr, rows, data_len);
        span = (cfg_view_rows != 0) ? cfg_view_rows * drc_pkg::BYTES_PER_ROW : 256;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: any op, any content
                add_edit(1'($urandom_range(0, 1)), $urandom, $urandom);
                queued++;
            end else begin
                // a run of records closed by a flush; long runs overflow the table
                k = $urandom_range(0, 10);
                for (i = 0; i < k; i++)
                    edit_q.push_back(random_record(span));
                add_edit(drc_pkg::OP_FLUSH, $urandom, $urandom);
                queued += k + 1;
            end
        end
        wait_idle();
    endtask

    initial begin
        int i;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: window 0x100..0x180, data well past it
        program_view(32'h100, 16'd8, 32'h1000);
        add_edit(drc_pkg::OP_FLUSH, '0, '0);                 // empty table -> whole grid
        add_edit(drc_pkg::OP_RECORD, 32'h123, '0);           // zero size, ignored
        add_edit(drc_pkg::OP_RECORD, drc_pkg::ADDR_ALL_ONES, 32'h4);  // invalid offset
        add_edit(drc_pkg::OP_RECORD, 32'h123, 32'h5);        // single row, exact columns
        add_edit(drc_pkg::OP_RECORD, 32'h200, 32'h10);       // outside the window
        add_edit(drc_pkg::OP_RECORD, 32'h150, 32'h20);       // spans rows
        add_edit(drc_pkg::OP_RECORD, 32'h128, 32'h8);        // touches first range, merges
        add_edit(drc_pkg::OP_RECORD, 32'hF0, 32'h14);        // clipped at window start
        add_edit(drc_pkg::OP_FLUSH, '1, '1);
        for (i = 0; i < drc_pkg::MAX_RANGES + 1; i++)        // overflow -> bounding range
            add_edit(drc_pkg::OP_RECORD, 32'h100 + 32'h20 * i, 32'h4);
        add_edit(drc_pkg::OP_FLUSH, '0, '0);
        add_edit(drc_pkg::OP_RECORD, 32'h0, 32'h1);
        for (i = 0; i < drc_pkg::MAX_RANGES - 2; i++)        // full table, max results per flush
            add_edit(drc_pkg::OP_RECORD, 32'h110 + 32'h10 * i, 32'h1);
        add_edit(drc_pkg::OP_RECORD, 32'hFFFF_FFFE, 32'hFFFF_FFFF);  // end beyond 32 bits
        add_edit(drc_pkg::OP_FLUSH, '0, '0);
        wait_idle();

        run_random_phase(32'h0, 16'd8, 32'h50, 55);                 // data ends mid-window
        run_random_phase(32'h1000, 16'd16, 32'hFFFF_FFFF, 55);
        run_random_phase(32'hFFFF_FFFE, 16'hFFFF, 32'hFFFF_FFFF, 40); // window past 4G
        run_random_phase(32'h40, 16'd0, 32'h1000, 25);              // no rows
        run_random_phase(32'hFFFF_FFFF, 16'd3, 32'hFFFF_FFFF, 20);  // unpaintable view
        run_random_phase(32'h20, 16'd10, 32'h0, 25);                // no data
        run_random_phase($urandom_range(0, 32'h400), 16'($urandom_range(1, 64)),
                         $urandom_range(0, 32'h1000), 50);
        idle_en = 1'b0;                             // closing stretch at full rate
        run_random_phase(32'h200, 16'd32, 32'h400, 40);

        $display("covered %0d record and %0d flush transactions over %0d view settings",
                 records_sent, flushes_sent, views_set);
        $display("checked %0d rects (%0d invalid), %0d long output stalls",
                 results_seen, invalid_seen, long_holds);
        if (mismatches == 0 && rect_expect_q.size() == 0) begin
            $display("** dirty_range_coalescer_unit: PASSED **");
        end else begin
            $display("** dirty_range_coalescer_unit: FAILED **");
        end
        $finish;
    end

endmodule

/* dirty_range_coalescer_unit.f */
+incdir+rtl
rtl/drc_pkg.sv
rtl/drc_cell.sv
rtl/drc_rect.sv
rtl/dirty_range_coalescer_unit.sv
sim/dirty_range_coalescer_unit_tb.sv
